FILE: rtl/core/face_square_roi_builder_core_defines.svh
// ----------------------------------------------------------------------------
// Face square ROI builder: assertion macros
// Shared concurrent assertion forms, clocked on clk with async reset rst_n.
// ----------------------------------------------------------------------------
`ifndef FACE_SQUARE_ROI_BUILDER_CORE_DEFINES_SVH
`define FACE_SQUARE_ROI_BUILDER_CORE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define FSRB_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define FSRB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/fsrb_pkg.sv
// ----------------------------------------------------------------------------
// Face square ROI builder package
// Fixed field widths, register indexes, reset values and the span bundle.
// ----------------------------------------------------------------------------
package fsrb_pkg;

    // Coordinate field width (signed / unsigned Q12.4 style fields).
    localparam int COORD_W    = 16;
    // Running minimum and maximum width, signed.
    localparam int SPAN_W     = 18;
    // Width of min + max and of max - min, signed.
    localparam int SUM_W      = 19;
    // Magnitude of a non-negative span.
    localparam int SPAN_MAG_W = 17;
    // Expand scale width, unsigned Q4.8.
    localparam int SCALE_W    = 12;
    // Configuration index width.
    localparam int CFG_IDX_W  = 2;

    // Register reset values.
    localparam int IMG_COLS_RST     = 640;
    localparam int IMG_ROWS_RST     = 480;
    localparam int EXPAND_SCALE_RST = 256;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMG_COLS     = 2'd0,
        CFG_IMG_ROWS     = 2'd1,
        CFG_EXPAND_SCALE = 2'd2
    } cfg_reg_t;

    // Bounding extent of one finished face.
    typedef struct packed {
        logic signed [SPAN_W-1:0] min_x;
        logic signed [SPAN_W-1:0] min_y;
        logic signed [SPAN_W-1:0] max_x;
        logic signed [SPAN_W-1:0] max_y;
    } span_box_t;

endpackage

FILE: rtl/core/fsrb_roi_calc.sv
// ----------------------------------------------------------------------------
// Face square ROI builder: crop calculation pipeline
// Three stages: span and multiply, side ceiling and clamp, placement.
// ----------------------------------------------------------------------------
`include "face_square_roi_builder_core_defines.svh"

module fsrb_roi_calc #(
    parameter int COORD_FRAC_BITS = 4,
    parameter int FRAME_DIM_BITS  = 12
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [FRAME_DIM_BITS-1:0]       img_cols,
    input  logic [FRAME_DIM_BITS-1:0]       img_rows,
    input  logic [fsrb_pkg::SCALE_W-1:0]    expand_scale,
    input  logic                            box_valid,
    output logic                            box_ready,
    input  fsrb_pkg::span_box_t             box,
    output logic                            roi_valid,
    input  logic                            roi_ready,
    output logic                            roi_ok,
    output logic [FRAME_DIM_BITS-1:0]       roi_left,
    output logic [FRAME_DIM_BITS-1:0]       roi_top,
    output logic [FRAME_DIM_BITS-1:0]       roi_side
);
    import fsrb_pkg::*;

    localparam int ProdW     = SPAN_MAG_W + SCALE_W;
    localparam int CeilShift = COORD_FRAC_BITS + 8;
    localparam int DimW      = FRAME_DIM_BITS;
    localparam int NW        = ((SUM_W > DimW + COORD_FRAC_BITS) ?
                                SUM_W : DimW + COORD_FRAC_BITS) + 2;
    localparam logic [ProdW:0]  RoundUp = (ProdW+1)'((1 << CeilShift) - 1);
    localparam logic [DimW-1:0] MinSide = DimW'(2);
    localparam logic [NW-1:0]   Half    = NW'(1) << COORD_FRAC_BITS;

    // Stage handshake.
    logic s2_valid_reg, s3_valid_reg, s4_valid_reg;
    logic s2_ready, s3_ready, s4_ready;
    logic s2_fire, s3_fire, box_fire;

    // Stage 2 registers.
    logic [ProdW-1:0]        prod_reg, prod_next;
    logic signed [SUM_W-1:0] s2_sum_x_reg, s2_sum_y_reg, sum_x_next, sum_y_next;
    logic                    s2_ok_reg, ok_next;

    // Stage 3 registers.
    logic [DimW-1:0]         side_reg, side_next;
    logic signed [SUM_W-1:0] s3_sum_x_reg, s3_sum_y_reg;
    logic                    s3_ok_reg;

    // Output registers.
    logic            roi_ok_reg, roi_ok_next;
    logic [DimW-1:0] roi_left_reg, roi_left_next;
    logic [DimW-1:0] roi_top_reg, roi_top_next;
    logic [DimW-1:0] roi_side_reg, roi_side_next;

    // Ready flows back stage by stage; an empty stage always takes a beat.
    assign s4_ready  = !s4_valid_reg || roi_ready;
    assign s3_ready  = !s3_valid_reg || s4_ready;
    assign s2_ready  = !s2_valid_reg || s3_ready;
    assign box_ready = s2_ready;
    assign box_fire  = box_valid && s2_ready;
    assign s2_fire   = s2_valid_reg && s3_ready;
    assign s3_fire   = s3_valid_reg && s4_ready;

    // Stage 2: larger span, scaled by the expand factor.
    always_comb
    begin
        logic signed [SUM_W-1:0] dx;
        logic signed [SUM_W-1:0] dy;
        logic signed [SUM_W-1:0] big;
        logic [SPAN_MAG_W-1:0]   mag;
        dx  = SUM_W'(box.max_x) - SUM_W'(box.min_x);
        dy  = SUM_W'(box.max_y) - SUM_W'(box.min_y);
        big = (dy > dx) ? dy : dx;
        mag = big[SUM_W-1] ? '0 : big[SPAN_MAG_W-1:0];
        prod_next  = ProdW'(mag) * ProdW'(expand_scale);
        sum_x_next = SUM_W'(box.min_x) + SUM_W'(box.max_x);
        sum_y_next = SUM_W'(box.min_y) + SUM_W'(box.max_y);
        ok_next    = (img_cols >= MinSide) && (img_rows >= MinSide);
    end

    // Stage 3: ceiling of the product, clamped to the smaller frame side, made even.
    always_comb
    begin
        logic [ProdW:0]  side_raw;
        logic [DimW-1:0] dim;
        logic [DimW-1:0] side_c;
        side_raw = ((ProdW+1)'(prod_reg) + RoundUp) >> CeilShift;
        dim      = (img_cols < img_rows) ? img_cols : img_rows;
        if (side_raw > (ProdW+1)'(dim))
        begin
            side_c = dim;
        end
        else if (side_raw < (ProdW+1)'(MinSide))
        begin
            side_c = MinSide;
        end
        else
        begin
            side_c = side_raw[DimW-1:0];
        end
        side_next = {side_c[DimW-1:1], 1'b0};
    end

    // Stage 4: rounded center minus half the side, clamped into the frame.
    function automatic logic [DimW-1:0] place(
        input logic signed [SUM_W-1:0] sum,
        input logic [DimW-1:0]         side,
        input logic [DimW-1:0]         frame_dim
    );
        logic signed [NW-1:0] n;
        logic [NW-1:0]        mag;
        logic [NW-1:0]        q;
        logic signed [NW-1:0] v;
        logic signed [NW-1:0] hi;
        n   = NW'(sum) - $signed(NW'(side) << COORD_FRAC_BITS);
        mag = n[NW-1] ? NW'(-n) : NW'(n);
        q   = (mag + Half) >> (COORD_FRAC_BITS + 1);
        v   = n[NW-1] ? -$signed(q) : $signed(q);
        hi  = $signed(NW'(frame_dim)) - $signed(NW'(side));
        if (v > hi)
        begin
            v = hi;
        end
        if (v < 0)
        begin
            v = '0;
        end
        return v[DimW-1:0];
    endfunction

    always_comb
    begin
        logic [DimW-1:0] left_c;
        left_c = place(s3_sum_x_reg, side_reg, img_cols);
        if (s3_ok_reg)
        begin
            roi_ok_next   = 1'b1;
            roi_left_next = {left_c[DimW-1:1], 1'b0};
            roi_top_next  = place(s3_sum_y_reg, side_reg, img_rows);
            roi_side_next = side_reg;
        end
        else
        begin
            roi_ok_next   = 1'b0;
            roi_left_next = '0;
            roi_top_next  = '0;
            roi_side_next = '0;
        end
    end

    // Stage valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            if (s2_ready)
            begin
                s2_valid_reg <= box_valid;
            end
            if (s3_ready)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (s4_ready)
            begin
                s4_valid_reg <= s3_valid_reg;
            end
        end
    end

    // Stage payloads.
    always_ff @(posedge clk)
    begin
        if (box_fire)
        begin
            prod_reg     <= prod_next;
            s2_sum_x_reg <= sum_x_next;
            s2_sum_y_reg <= sum_y_next;
            s2_ok_reg    <= ok_next;
        end
        if (s2_fire)
        begin
            side_reg     <= side_next;
            s3_sum_x_reg <= s2_sum_x_reg;
            s3_sum_y_reg <= s2_sum_y_reg;
            s3_ok_reg    <= s2_ok_reg;
        end
        if (s3_fire)
        begin
            roi_ok_reg   <= roi_ok_next;
            roi_left_reg <= roi_left_next;
            roi_top_reg  <= roi_top_next;
            roi_side_reg <= roi_side_next;
        end
    end

    assign roi_valid = s4_valid_reg;
    assign roi_ok    = roi_ok_reg;
    assign roi_left  = roi_left_reg;
    assign roi_top   = roi_top_reg;
    assign roi_side  = roi_side_reg;

    // Checks on the finished crop.
    logic [DimW:0] roi_right;
    assign roi_right = (DimW+1)'(roi_left) + (DimW+1)'(roi_side);

    `FSRB_ASSERT_NOW(a_crop_even, roi_valid && roi_ok,
        !roi_side[0] && !roi_left[0] && (roi_side >= MinSide), "crop side or left not even")
    `FSRB_ASSERT_NOW(a_crop_zero, roi_valid && !roi_ok,
        (roi_left == '0) && (roi_top == '0) && (roi_side == '0), "failed crop not zero")
    `FSRB_ASSERT_NOW(a_crop_fits, roi_valid && roi_ok,
        (roi_right <= (DimW+1)'(img_cols)) && (roi_side <= img_rows),
        "crop leaves the frame")

endmodule

FILE: rtl/core/face_square_roi_builder_core.sv
// ----------------------------------------------------------------------------
// Face square ROI builder
// Tracks the extent of a face box and its landmarks and builds a square crop.
// ----------------------------------------------------------------------------
//  Channel | Direction | Handshake              | Beat carries
//  item    | in        | item_valid/item_ready  | item_x, item_y, item_width,
//          |           |                        | item_height, last_item
//  roi     | out       | roi_valid/roi_ready    | roi_ok, roi_left, roi_top, roi_side
//  cfg     | in        | cfg_write, no stall    | cfg_index, cfg_data
//
//  One item beat is taken per cycle while item_ready is high; the result of a last
//  item passes through the input register, the span update and three crop stages
//  (multiply, side clamp, placement).
//  Reset loads the frame size 640 x 480 and scale 1.0 and clears the running extent.
//  A stalled roi channel fills the crop stages; item beats without last_item keep
//  flowing, and a last item waits only when the crop pipeline is full.
// ----------------------------------------------------------------------------
`include "face_square_roi_builder_core_defines.svh"

module face_square_roi_builder_core #(
    parameter int COORD_FRAC_BITS = 4,
    parameter int FRAME_DIM_BITS  = 12
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    cfg_write,
    input  logic [fsrb_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [((FRAME_DIM_BITS > fsrb_pkg::SCALE_W) ?
                   FRAME_DIM_BITS : fsrb_pkg::SCALE_W)-1:0] cfg_data,
    input  logic                                    item_valid,
    output logic                                    item_ready,
    input  logic signed [fsrb_pkg::COORD_W-1:0]     item_x,
    input  logic signed [fsrb_pkg::COORD_W-1:0]     item_y,
    input  logic [fsrb_pkg::COORD_W-1:0]            item_width,
    input  logic [fsrb_pkg::COORD_W-1:0]            item_height,
    input  logic                                    last_item,
    output logic                                    roi_valid,
    input  logic                                    roi_ready,
    output logic                                    roi_ok,
    output logic [FRAME_DIM_BITS-1:0]               roi_left,
    output logic [FRAME_DIM_BITS-1:0]               roi_top,
    output logic [FRAME_DIM_BITS-1:0]               roi_side
);
    import fsrb_pkg::*;

    // Configuration registers.
    logic [FRAME_DIM_BITS-1:0] img_cols_reg, img_rows_reg;
    logic [SCALE_W-1:0]        expand_scale_reg;

    // Input register.
    logic                      in_valid_reg;
    logic signed [COORD_W-1:0] in_x_reg, in_y_reg;
    logic [COORD_W-1:0]        in_w_reg, in_h_reg;
    logic                      in_last_reg;
    logic                      in_fire;

    // Running extent.
    logic signed [SPAN_W-1:0] span_min_x_reg, span_min_y_reg;
    logic signed [SPAN_W-1:0] span_max_x_reg, span_max_y_reg;
    logic                     collecting_reg, collecting_next;
    span_box_t                span_next;

    // Finished face handed to the crop pipeline.
    logic      box_valid_reg, box_valid_next;
    span_box_t box_reg;
    logic      box_ready;
    logic      box_fire;

    // Configuration writes; an unused index is dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            img_cols_reg     <= FRAME_DIM_BITS'(IMG_COLS_RST);
            img_rows_reg     <= FRAME_DIM_BITS'(IMG_ROWS_RST);
            expand_scale_reg <= SCALE_W'(EXPAND_SCALE_RST);
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_IMG_COLS:     img_cols_reg     <= cfg_data[FRAME_DIM_BITS-1:0];
                CFG_IMG_ROWS:     img_rows_reg     <= cfg_data[FRAME_DIM_BITS-1:0];
                CFG_EXPAND_SCALE: expand_scale_reg <= cfg_data[SCALE_W-1:0];
                default:          ;
            endcase
        end
    end

    // A middle item always retires; a last item needs room in the crop stage.
    assign box_fire   = box_valid_reg && box_ready;
    assign in_fire    = in_valid_reg && (!in_last_reg || !box_valid_reg || box_ready);
    assign item_ready = !in_valid_reg || in_fire;

    // Merge the item into the running extent, or start a new face.
    always_comb
    begin
        logic signed [SPAN_W-1:0] x1;
        logic signed [SPAN_W-1:0] y1;
        logic signed [SPAN_W-1:0] x2;
        logic signed [SPAN_W-1:0] y2;
        x1 = SPAN_W'(in_x_reg);
        y1 = SPAN_W'(in_y_reg);
        x2 = x1 + $signed(SPAN_W'(in_w_reg));
        y2 = y1 + $signed(SPAN_W'(in_h_reg));
        if (!collecting_reg)
        begin
            span_next.min_x = x1;
            span_next.min_y = y1;
            span_next.max_x = x2;
            span_next.max_y = y2;
        end
        else
        begin
            span_next.min_x = (x1 < span_min_x_reg) ? x1 : span_min_x_reg;
            span_next.min_y = (y1 < span_min_y_reg) ? y1 : span_min_y_reg;
            span_next.max_x = (x2 > span_max_x_reg) ? x2 : span_max_x_reg;
            span_next.max_y = (y2 > span_max_y_reg) ? y2 : span_max_y_reg;
        end
        collecting_next = !in_last_reg;
        box_valid_next  = (in_fire && in_last_reg) || (box_valid_reg && !box_ready);
    end

    // Control and extent state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            box_valid_reg  <= 1'b0;
            collecting_reg <= 1'b0;
            span_min_x_reg <= '0;
            span_min_y_reg <= '0;
            span_max_x_reg <= '0;
            span_max_y_reg <= '0;
        end
        else
        begin
            if (item_ready)
            begin
                in_valid_reg <= item_valid;
            end
            box_valid_reg <= box_valid_next;
            if (in_fire)
            begin
                collecting_reg <= collecting_next;
                span_min_x_reg <= span_next.min_x;
                span_min_y_reg <= span_next.min_y;
                span_max_x_reg <= span_next.max_x;
                span_max_y_reg <= span_next.max_y;
            end
        end
    end

    // Item and finished-face payloads.
    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            in_x_reg    <= item_x;
            in_y_reg    <= item_y;
            in_w_reg    <= item_width;
            in_h_reg    <= item_height;
            in_last_reg <= last_item;
        end
        if (in_fire && in_last_reg)
        begin
            box_reg <= span_next;
        end
    end

    // Crop calculation.
    fsrb_roi_calc #(
        .COORD_FRAC_BITS (COORD_FRAC_BITS),
        .FRAME_DIM_BITS  (FRAME_DIM_BITS)
    ) u_roi_calc (
        .clk          (clk),
        .rst_n        (rst_n),
        .img_cols     (img_cols_reg),
        .img_rows     (img_rows_reg),
        .expand_scale (expand_scale_reg),
        .box_valid    (box_valid_reg),
        .box_ready    (box_ready),
        .box          (box_reg),
        .roi_valid    (roi_valid),
        .roi_ready    (roi_ready),
        .roi_ok       (roi_ok),
        .roi_left     (roi_left),
        .roi_top      (roi_top),
        .roi_side     (roi_side)
    );

    // Checks on the running extent.
    `FSRB_ASSERT_NOW(a_extent_order, collecting_reg,
        (span_min_x_reg <= span_max_x_reg) && (span_min_y_reg <= span_max_y_reg),
        "running extent inverted")
    `FSRB_ASSERT_NEXT(a_face_ends, in_fire && in_last_reg,
        !collecting_reg && box_valid_reg, "last item did not close the face")
    `FSRB_ASSERT_NEXT(a_face_grows, in_fire && !in_last_reg,
        collecting_reg, "middle item did not keep the face open")

endmodule
